### rtl/core/xalu_pkg.sv
// ----------------------------------------------------------------------------
// xalu_pkg
// Shared types, operation codes and helpers of the 16-bit x86 ALU.
// ----------------------------------------------------------------------------
package xalu_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [11:0] FLAGS_FIXED = 12'h002;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_OR = 5'd1, OP_ADC = 5'd2, OP_SBB = 5'd3,
        OP_AND = 5'd4, OP_SUB = 5'd5, OP_XOR = 5'd6, OP_CMP = 5'd7,
        OP_TEST = 5'd8, OP_INC = 5'd9, OP_DEC = 5'd10, OP_NEG = 5'd11,
        OP_NOT = 5'd12, OP_ROL = 5'd13, OP_ROR = 5'd14, OP_RCL = 5'd15,
        OP_RCR = 5'd16, OP_SHL = 5'd17, OP_SHR = 5'd18, OP_SAR = 5'd19,
        OP_MUL = 5'd20, OP_IMUL = 5'd21, OP_DIV = 5'd22, OP_IDIV = 5'd23,
        OP_AAM = 5'd24, OP_AAD = 5'd25, OP_CLC = 5'd26, OP_STC = 5'd27,
        OP_CMC = 5'd28, OP_LDF = 5'd29, OP_NONE30 = 5'd30, OP_NONE31 = 5'd31
    } t_op;

    // Unit class chosen by the front end.
    typedef enum logic [1:0] {
        CL_SIMPLE = 2'd0, CL_MUL = 2'd1, CL_DIV = 2'd2
    } t_class;

    typedef struct packed {
        logic [4:0]  cmd;
        logic        wide;
        logic [15:0] dest_value;
        logic [15:0] source_value;
        logic [15:0] upper_dividend;
        logic [4:0]  shift_count;
    } t_in;

    typedef struct packed {
        logic [15:0] result_low;
        logic [15:0] result_high;
        logic [11:0] flags_out;
        logic        write_back;
        logic        divide_error;
    } t_out;

    typedef struct packed {
        t_in    item;
        t_class cls;
    } t_qent;

    // Flag vector order: {OF, SF, ZF, AF, PF, CF}
    function automatic logic [11:0] pack_flags(input logic [5:0] f);
        logic [11:0] v;
        v = FLAGS_FIXED;
        v[0] = f[0]; v[2] = f[1]; v[4] = f[2];
        v[6] = f[3]; v[7] = f[4]; v[11] = f[5];
        return v;
    endfunction

endpackage

### rtl/core/x86_16bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// x86_16bit_alu_with_flags
// 16-bit x86 execution unit with arithmetic flags.
// ----------------------------------------------------------------------------
// Operations arrive on the input valid/ready channel, one transaction each,
// and every operation yields exactly one result transaction. A front stage
// classifies each operation and places it in a two-entry queue; the back
// end executes it and holds its result in an output register.
// Simple operations (arithmetic, logic, shifts, rotates, aad, flag
// operations) pass through the queue and then the output register, and
// one operation per cycle is sustained while the receiver takes each result,
// since the output register frees on the same edge that reloads it.
// Multiply has one registered multiplier stage before the output register,
// and the back end takes no new operation while it is in S_MUL.
// Divide, idiv and aam run a restoring divider at one quotient bit per
// cycle through S_DIV and then S_DONE; a zero divisor ends at once like a
// simple operation.
// Reset clears the flags, the queue and the aux-flag enable register.
// When the receiver stalls, the result holds, the back end stops, and the
// queue fills before the input deasserts ready.
// Register 0 (byte address 0): aux_flag_enable, written over APB.
// ----------------------------------------------------------------------------
module x86_16bit_alu_with_flags #(
    parameter int QUEUE_DEPTH = xalu_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  xalu_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output xalu_pkg::t_out  o_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [1:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    logic r_aux_en;
    logic q_valid, q_ready;
    xalu_pkg::t_qent q_ent;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'b0, r_aux_en} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_aux_en <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0) r_aux_en <= pwdata[0];
    end

    xalu_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(i_data),
        .o_valid(q_valid), .i_ready(q_ready), .o_ent(q_ent)
    );

    xalu_back u_back (
        .i_clk, .i_rst_n, .i_aux_en(r_aux_en),
        .i_valid(q_valid), .o_ready(q_ready), .i_ent(q_ent),
        .o_valid, .i_ready, .o_out(o_data)
    );
endmodule

### rtl/core/xalu_front.sv
// ----------------------------------------------------------------------------
// xalu_front
// Accepts operations, tags each with its execution class, and queues them.
// ----------------------------------------------------------------------------
module xalu_front #(
    parameter int DEPTH = xalu_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  xalu_pkg::t_in    i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output xalu_pkg::t_qent  o_ent
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    xalu_pkg::t_qent r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    xalu_pkg::t_class cls;
    logic push, pop;

    always_comb begin
        case (xalu_pkg::t_op'(i_item.cmd))
            xalu_pkg::OP_MUL, xalu_pkg::OP_IMUL: cls = xalu_pkg::CL_MUL;
            xalu_pkg::OP_DIV, xalu_pkg::OP_IDIV, xalu_pkg::OP_AAM:
                cls = xalu_pkg::CL_DIV;
            default: cls = xalu_pkg::CL_SIMPLE;
        endcase
    end

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= '{item: i_item, cls: cls};
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

### rtl/core/xalu_back.sv
// ----------------------------------------------------------------------------
// xalu_back
// Executes queued operations and owns the arithmetic flags. Multiply has
// one registered stage; divide and aam run a restoring divider, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module xalu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_aux_en,
    input  logic             i_valid,
    output logic             o_ready,
    input  xalu_pkg::t_qent  i_ent,
    output logic             o_valid,
    input  logic             i_ready,
    output xalu_pkg::t_out   o_out
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;

    t_state          r_state;
    logic [5:0]      r_flags;
    xalu_pkg::t_in   r_it;
    logic [31:0]     r_prod;
    logic [31:0]     r_rem;      // remainder in upper bits; the dividend shifts through r_quo
    logic [31:0]     r_quo;
    logic [15:0]     r_dvs;
    logic [4:0]      r_cnt;
    logic            r_qneg, r_rneg;
    logic            r_ovalid;
    xalu_pkg::t_out  r_out;

    // Simple-op combinational path.
    logic [5:0]  s_flags;
    logic [15:0] s_res;
    logic        s_wb;

    function automatic logic par(input logic [7:0] v);
        return ~^v;
    endfunction

    always_comb begin
        logic [15:0] d, s, mask, msb, r;
        logic [16:0] t;
        logic        cf, c, w;
        logic [4:0]  n, k;
        logic [4:0]  wb5;
        logic [16:0] v;
        logic [31:0] sh;
        logic [15:0] aad;
        xalu_pkg::t_in it;
        it = i_ent.item;
        w = it.wide;
        mask = w ? 16'hFFFF : 16'h00FF;
        msb  = w ? 16'h8000 : 16'h0080;
        wb5  = w ? 5'd16 : 5'd8;
        d = it.dest_value & mask;
        s = it.source_value & mask;
        n = it.shift_count;
        cf = r_flags[0];
        s_flags = r_flags;
        s_res = '0; s_wb = 1'b0;
        r = '0; t = '0; c = 1'b0; k = '0; v = '0; sh = '0; aad = '0;
        case (xalu_pkg::t_op'(it.cmd))
            xalu_pkg::OP_ADD, xalu_pkg::OP_ADC: begin
                c = (it.cmd == xalu_pkg::OP_ADC) && cf;
                t = {1'b0, d} + {1'b0, s} + 17'(c);
                r = t[15:0] & mask;
                s_flags[0] = w ? t[16] : t[8];
                s_flags[5] = |((d ^ r) & (s ^ r) & msb);
                if (i_aux_en) s_flags[2] = d[4] ^ s[4] ^ r[4];
                s_res = r; s_wb = 1'b1;
            end
            xalu_pkg::OP_SUB, xalu_pkg::OP_SBB, xalu_pkg::OP_CMP: begin
                c = (it.cmd == xalu_pkg::OP_SBB) && cf;
                t = {1'b0, d} - {1'b0, s} - 17'(c);
                r = t[15:0] & mask;
                s_flags[0] = t[16];
                s_flags[5] = |((d ^ s) & (d ^ r) & msb);
                if (i_aux_en) s_flags[2] = d[4] ^ s[4] ^ r[4];
                s_res = r; s_wb = (it.cmd != xalu_pkg::OP_CMP);
            end
            xalu_pkg::OP_OR, xalu_pkg::OP_AND, xalu_pkg::OP_XOR,
            xalu_pkg::OP_TEST: begin
                r = (it.cmd == xalu_pkg::OP_OR) ? (d | s) :
                    (it.cmd == xalu_pkg::OP_XOR) ? (d ^ s) : (d & s);
                s_flags[0] = 1'b0; s_flags[5] = 1'b0;
                s_res = r; s_wb = (it.cmd != xalu_pkg::OP_TEST);
            end
            xalu_pkg::OP_INC, xalu_pkg::OP_DEC: begin
                r = ((it.cmd == xalu_pkg::OP_INC) ? d + 16'd1 : d - 16'd1) & mask;
                s_flags[5] = (it.cmd == xalu_pkg::OP_INC) ? (r == msb) : (d == msb);
                if (i_aux_en) s_flags[2] = d[4] ^ r[4];
                s_res = r; s_wb = 1'b1;
            end
            xalu_pkg::OP_NEG: begin
                r = (16'd0 - d) & mask;
                s_flags[0] = (d != 0);
                s_flags[5] = (d == msb);
                if (i_aux_en) s_flags[2] = d[4] ^ r[4];
                s_res = r; s_wb = 1'b1;
            end
            xalu_pkg::OP_NOT: begin
                s_res = ~d & mask; s_wb = 1'b1;
            end
            xalu_pkg::OP_ROL, xalu_pkg::OP_ROR: begin
                s_res = d; s_wb = 1'b1;
                if (n != 0) begin
                    k = w ? {1'b0, n[3:0]} : {2'b0, n[2:0]};
                    sh = w ? {d, d} : {16'b0, d[7:0], d[7:0]};
                    if (it.cmd == xalu_pkg::OP_ROL)
                        r = w ? 16'((sh << k) >> 16) : {8'b0, 8'((sh << k) >> 8)};
                    else
                        r = 16'(sh >> k) & mask;
                    if (it.cmd == xalu_pkg::OP_ROL) begin
                        s_flags[0] = r[0];
                        s_flags[5] = (|(r & msb)) ^ r[0];
                    end else begin
                        s_flags[0] = |(r & msb);
                        s_flags[5] = (|(r & msb)) ^ (w ? r[14] : r[6]);
                    end
                    s_res = r;
                end
            end
            xalu_pkg::OP_RCL, xalu_pkg::OP_RCR: begin
                s_res = d; s_wb = 1'b1;
                if (n != 0) begin
                    // count mod 17 (word) or mod 9 (byte), with n below 32
                    if (w) k = (n >= 5'd17) ? n - 5'd17 : n;
                    else k = (n >= 5'd27) ? n - 5'd27 : (n >= 5'd18) ? n - 5'd18 :
                             (n >= 5'd9) ? n - 5'd9 : n;
                    v = w ? {cf, d} : {8'b0, cf, d[7:0]};
                    for (int i = 0; i < 17; i++) begin
                        if (5'(i) < k) begin
                            if (it.cmd == xalu_pkg::OP_RCL)
                                v = w ? {v[15:0], v[16]} : {8'b0, v[7:0], v[8]};
                            else
                                v = w ? {v[0], v[16:1]} : {8'b0, v[0], v[8:1]};
                        end
                    end
                    r = v[15:0] & mask;
                    c = w ? v[16] : v[8];
                    s_flags[0] = c;
                    if (it.cmd == xalu_pkg::OP_RCL) s_flags[5] = (|(r & msb)) ^ c;
                    else s_flags[5] = (|(r & msb)) ^ (w ? r[14] : r[6]);
                    s_res = r;
                end
            end
            xalu_pkg::OP_SHL, xalu_pkg::OP_SHR, xalu_pkg::OP_SAR: begin
                s_res = d; s_wb = 1'b1;
                if (n != 0) begin
                    if (it.cmd == xalu_pkg::OP_SHL) begin
                        sh = {16'b0, d} << n;
                        r = sh[15:0] & mask;
                        c = (n <= wb5) ? (w ? sh[16] : sh[8]) : 1'b0;
                        s_flags[5] = (|(r & msb)) ^ c;
                    end else if (it.cmd == xalu_pkg::OP_SHR) begin
                        sh = {d, 16'b0} >> n;
                        r = sh[31:16];
                        c = sh[15];
                        s_flags[5] = |(d & msb);
                    end else begin
                        sh = w ? {{16{d[15]}}, d} : {{24{d[7]}}, d[7:0]};
                        sh = 32'($signed({sh, 1'b0}) >>> n);
                        r = sh[16:1] & mask;
                        c = sh[0];
                        s_flags[5] = 1'b0;
                    end
                    s_flags[0] = c;
                    s_res = r;
                end
            end
            xalu_pkg::OP_AAD: begin
                aad = 16'(it.dest_value[15:8] * it.source_value[7:0]);
                r = {8'b0, it.dest_value[7:0] + aad[7:0]};
                s_flags[0] = 1'b0; s_flags[5] = 1'b0;
                s_res = r; s_wb = 1'b1;
            end
            xalu_pkg::OP_CLC: s_flags[0] = 1'b0;
            xalu_pkg::OP_STC: s_flags[0] = 1'b1;
            xalu_pkg::OP_CMC: s_flags[0] = ~cf;
            xalu_pkg::OP_LDF: begin
                s_flags = {it.source_value[11], it.source_value[7],
                           it.source_value[6], it.source_value[4],
                           it.source_value[2], it.source_value[0]};
            end
            default: ;
        endcase
        // Result flags S, Z, P where the operation defines them.
        case (xalu_pkg::t_op'(it.cmd))
            xalu_pkg::OP_ADD, xalu_pkg::OP_ADC, xalu_pkg::OP_SUB,
            xalu_pkg::OP_SBB, xalu_pkg::OP_CMP, xalu_pkg::OP_OR,
            xalu_pkg::OP_AND, xalu_pkg::OP_XOR, xalu_pkg::OP_TEST,
            xalu_pkg::OP_INC, xalu_pkg::OP_DEC, xalu_pkg::OP_NEG,
            xalu_pkg::OP_AAD: begin
                s_flags[3] = (r == 0); s_flags[4] = |(r & msb); s_flags[1] = par(r[7:0]);
                if (it.cmd == xalu_pkg::OP_AAD) s_flags[4] = r[7];
            end
            xalu_pkg::OP_SHL, xalu_pkg::OP_SHR, xalu_pkg::OP_SAR: begin
                if (n != 0) begin
                    s_flags[3] = (r == 0); s_flags[4] = |(r & msb);
                    s_flags[1] = par(r[7:0]);
                end
            end
            default: ;
        endcase
    end

    // Divider operands, taken as magnitudes.
    logic [31:0] dd_mag;
    logic [15:0] dv_mag;
    logic        dd_neg, dv_neg, dv_zero;
    always_comb begin
        xalu_pkg::t_in it;
        logic [31:0] nd;
        logic [15:0] dv;
        it = i_ent.item;
        dd_neg = 1'b0; dv_neg = 1'b0;
        case (xalu_pkg::t_op'(it.cmd))
            xalu_pkg::OP_DIV: begin
                nd = it.wide ? {it.upper_dividend, it.dest_value} : {16'b0, it.dest_value};
                dv = it.wide ? it.source_value : {8'b0, it.source_value[7:0]};
            end
            xalu_pkg::OP_IDIV: begin
                nd = it.wide ? {it.upper_dividend, it.dest_value}
                             : {{16{it.dest_value[15]}}, it.dest_value};
                dv = it.wide ? it.source_value
                             : {{8{it.source_value[7]}}, it.source_value[7:0]};
                dd_neg = nd[31]; dv_neg = dv[15];
                if (dd_neg) nd = -nd;
                if (dv_neg) dv = -dv;
            end
            default: begin
                nd = {24'b0, it.dest_value[7:0]};
                dv = {8'b0, it.source_value[7:0]};
            end
        endcase
        dd_mag = nd; dv_mag = dv; dv_zero = (dv == 0);
    end

    // One restoring step.
    logic [16:0] trial;
    always_comb begin
        trial = {r_rem[31:16], r_quo[31]} - {1'b0, r_dvs};
    end

    // Multiply operands.
    logic signed [16:0] ma, mb;
    always_comb begin
        xalu_pkg::t_in it;
        it = i_ent.item;
        if (it.cmd == xalu_pkg::OP_IMUL) begin
            ma = it.wide ? {it.dest_value[15], it.dest_value}
                         : {{9{it.dest_value[7]}}, it.dest_value[7:0]};
            mb = it.wide ? {it.source_value[15], it.source_value}
                         : {{9{it.source_value[7]}}, it.source_value[7:0]};
        end else begin
            ma = it.wide ? {1'b0, it.dest_value} : {9'b0, it.dest_value[7:0]};
            mb = it.wide ? {1'b0, it.source_value} : {9'b0, it.source_value[7:0]};
        end
    end

    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    function automatic xalu_pkg::t_out de_out(input xalu_pkg::t_in it, input logic [5:0] f);
        xalu_pkg::t_out o;
        o.result_low = it.dest_value;
        o.result_high = (it.wide && (it.cmd == xalu_pkg::OP_DIV || it.cmd == xalu_pkg::OP_IDIV))
                        ? it.upper_dividend : 16'b0;
        o.flags_out = xalu_pkg::pack_flags(f);
        o.write_back = 1'b0;
        o.divide_error = 1'b1;
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        logic [15:0] q, rm, pl, ph;
        logic        ovf, cfm;
        logic [5:0]  f;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_flags <= '0; r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_it <= i_ent.item;
                        case (i_ent.cls)
                            xalu_pkg::CL_MUL: begin
                                r_prod <= 32'(ma * mb);
                                r_state <= S_MUL;
                            end
                            xalu_pkg::CL_DIV: begin
                                if (dv_zero) begin
                                    r_out <= de_out(i_ent.item, r_flags);
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_rem <= '0; r_quo <= dd_mag; r_dvs <= dv_mag;
                                    r_qneg <= dd_neg ^ dv_neg; r_rneg <= dd_neg;
                                    r_cnt <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                r_flags <= s_flags;
                                r_out.result_low <= s_res;
                                r_out.result_high <= '0;
                                r_out.flags_out <= xalu_pkg::pack_flags(s_flags);
                                r_out.write_back <= s_wb;
                                r_out.divide_error <= 1'b0;
                                r_ovalid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    f = r_flags;
                    if (r_it.cmd == xalu_pkg::OP_IMUL)
                        cfm = r_it.wide ? (r_prod[31:15] != {17{r_prod[15]}})
                                        : (r_prod[15:7] != {9{r_prod[7]}});
                    else
                        cfm = r_it.wide ? (r_prod[31:16] != 0) : (r_prod[15:8] != 0);
                    f[0] = cfm; f[5] = cfm;
                    r_flags <= f;
                    r_out.result_low <= r_prod[15:0];
                    r_out.result_high <= r_it.wide ? r_prod[31:16] : 16'b0;
                    r_out.flags_out <= xalu_pkg::pack_flags(f);
                    r_out.write_back <= 1'b1;
                    r_out.divide_error <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    // Shift one dividend bit into the partial remainder.
                    if (!trial[16]) r_rem[31:16] <= trial[15:0];
                    else r_rem[31:16] <= {r_rem[30:16], r_quo[31]};
                    r_quo <= {r_quo[30:0], ~trial[16]};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) r_state <= S_DONE;
                end
                S_DONE: begin
                    f = r_flags;
                    q  = r_qneg ? 16'(-r_quo) : r_quo[15:0];
                    rm = r_rneg ? -r_rem[31:16] : r_rem[31:16];
                    case (xalu_pkg::t_op'(r_it.cmd))
                        xalu_pkg::OP_DIV:
                            ovf = r_it.wide ? (r_quo[31:16] != 0) : (r_quo[31:8] != 0);
                        xalu_pkg::OP_IDIV:
                            ovf = r_it.wide
                                ? (r_qneg ? (r_quo > 32'h8000) : (r_quo > 32'h7FFF))
                                : (r_qneg ? (r_quo > 32'h80) : (r_quo > 32'h7F));
                        default: ovf = 1'b0;
                    endcase
                    if (ovf) begin
                        r_out <= de_out(r_it, r_flags);
                    end else begin
                        pl = q; ph = '0;
                        if (r_it.cmd == xalu_pkg::OP_AAM) begin
                            pl = {r_quo[7:0], r_rem[23:16]};
                            f[3] = (r_rem[23:16] == 0); f[4] = r_rem[23];
                            f[1] = par(r_rem[23:16]); f[0] = 1'b0; f[5] = 1'b0;
                        end else if (r_it.wide) begin
                            ph = rm;
                        end else begin
                            pl = {rm[7:0], q[7:0]};
                        end
                        r_flags <= f;
                        r_out.result_low <= pl;
                        r_out.result_high <= ph;
                        r_out.flags_out <= xalu_pkg::pack_flags(f);
                        r_out.write_back <= 1'b1;
                        r_out.divide_error <= 1'b0;
                    end
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
